// ===== design/block_hash_compression_macros.svh =====
// Assertion macros shared by the block hash compression design.
`ifndef BLOCK_HASH_COMPRESSION_MACROS_SVH
`define BLOCK_HASH_COMPRESSION_MACROS_SVH

`ifndef NO_ASSERTIONS
`define BHC_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("block_hash_compression: property violated");
`define BHC_ASSERT_NEVER(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("block_hash_compression: forbidden condition seen");
`else
`define BHC_ASSERT(label, prop)
`define BHC_ASSERT_NEVER(label, cond)
`endif

`endif

// ===== design/bhc_pkg.sv =====
// Types, constants and the round constant table of the block hash compression.
package bhc_pkg;

    localparam int WORD_W      = 64;
    localparam int MSG_DEPTH   = 16;
    localparam int MSG_AW      = 4;
    localparam int CHAIN_DEPTH = 8;
    localparam int CHAIN_AW    = 3;
    localparam int ROUND_COUNT = 16;
    localparam int ROUND_W     = 4;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [CHAIN_DEPTH-1:0][WORD_W-1:0] work_t;

    localparam word_t IV_RESET = 64'h0000_0000_6a09_e667;

    localparam word_t ROUND_CONST [16] = '{
        64'h0000_0000_428a_2f98, 64'h0000_0000_7137_4491,
        64'h0000_0000_b5c0_fbcf, 64'h0000_0000_e9b5_dba5,
        64'h0000_0000_3956_c25b, 64'h0000_0000_59f1_11f1,
        64'h0000_0000_923f_82a4, 64'h0000_0000_ab1c_5ed5,
        64'h0000_0000_d807_aa98, 64'h0000_0000_1283_5b01,
        64'h0000_0000_2431_85be, 64'h0000_0000_550c_7dc3,
        64'h0000_0000_72be_5d74, 64'h0000_0000_80de_b1fe,
        64'h0000_0000_9bdc_06a7, 64'h0000_0000_c19b_f174
    };

    typedef enum logic [1:0] {
        STEP_FIRST,
        STEP_SECOND,
        STEP_THIRD,
        STEP_LAST
    } step_t;

    typedef struct packed {
        step_t step;
        word_t round_const;
    } step_ctl_t;

endpackage

// ===== design/bhc_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module bhc_ram #(
    parameter int Width = 64,
    parameter int Depth = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);

    logic [Width-1:0] mem_reg [Depth];
    logic [Width-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/bhc_step.sv =====
// One add-and-rotate step of a compression round.
module bhc_step (
    input  bhc_pkg::work_t     work,
    input  bhc_pkg::word_t     t_prev,
    input  bhc_pkg::word_t     msg,
    input  bhc_pkg::step_ctl_t ctl,
    output bhc_pkg::word_t     t_out
);

    import bhc_pkg::*;

    word_t prev;
    word_t ch_a;
    word_t ch_b;
    word_t ch_c;
    word_t base;
    word_t k_add;
    word_t sum;
    word_t rot;

    always_comb
    begin
        prev  = t_prev;
        k_add = '0;
        case (ctl.step)
            STEP_FIRST:
            begin
                prev  = work[0];
                ch_a  = work[4];
                ch_b  = work[1];
                ch_c  = work[2];
                base  = work[7];
                k_add = ctl.round_const;
            end
            STEP_SECOND:
            begin
                ch_a = work[5];
                ch_b = work[0];
                ch_c = work[1];
                base = work[3];
            end
            STEP_THIRD:
            begin
                ch_a = work[6];
                ch_b = work[3];
                ch_c = work[0];
                base = work[2];
            end
            default:
            begin
                ch_a = work[7];
                ch_b = work[2];
                ch_c = work[3];
                base = work[1];
            end
        endcase

        sum = prev + (ch_a ^ (ch_b & (ch_c ^ ch_a))) + msg + k_add;

        case (ctl.step)
            STEP_FIRST:  rot = {sum[0],    sum[63:1]};
            STEP_SECOND: rot = {sum[7:0],  sum[63:8]};
            STEP_THIRD:  rot = {sum[14:0], sum[63:15]};
            default:     rot = {sum[21:0], sum[63:22]};
        endcase

        t_out = base + rot;
    end

endmodule

// ===== design/block_hash_compression.sv =====
// Top level of the block hash compression: sequencer, working words and memories.
//
// Channel   Direction  Handshake             Payload
// in        input      in_valid / in_ready   message_word, restart_chain
// out       output     out_valid / out_ready hash_word, word_index, last_word
// cfg       input      cfg_we                cfg_wdata
//
// A block takes sixteen input transactions, then loads the working words from the
// chaining memory, then runs sixteen rounds, one step per cycle, paced by the single
// read port of the message memory. Each of the eight results then takes a chaining
// memory read, then an add and write back, which waits while the previous result is
// held with out_ready low; input is taken only between blocks' results.
// After reset the chaining words read as the initial value followed by zeros at once.
`include "block_hash_compression_macros.svh"

module block_hash_compression (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  bhc_pkg::word_t message_word,
    input  logic           restart_chain,
    output logic           out_valid,
    input  logic           out_ready,
    output bhc_pkg::word_t hash_word,
    output logic [2:0]     word_index,
    output logic           last_word,
    input  logic           cfg_we,
    input  bhc_pkg::word_t cfg_wdata
);

    import bhc_pkg::*;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_INIT,
        ST_ROUND,
        ST_FIN_RD,
        ST_FIN_ADD
    } state_t;

    localparam logic [MSG_AW-1:0]   LAST_WORD_CNT = MSG_AW'(MSG_DEPTH - 1);
    localparam logic [CHAIN_AW-1:0] LAST_CHAIN    = CHAIN_AW'(CHAIN_DEPTH - 1);
    localparam logic [ROUND_W-1:0]  LAST_ROUND    = ROUND_W'(ROUND_COUNT - 1);
    localparam logic [3:0]          INIT_DONE     = 4'(CHAIN_DEPTH);

    state_t              state_reg;
    logic [MSG_AW-1:0]   word_cnt_reg;
    logic [3:0]          seq_cnt_reg;
    logic [ROUND_W-1:0]  round_cnt_reg;
    logic [1:0]          step_cnt_reg;
    logic                fresh_reg;
    word_t               fresh_val_reg;
    word_t               iv_reg;
    work_t               work_reg;
    word_t               t_reg;
    word_t               t1_reg;
    logic                out_valid_reg;
    word_t               out_word_reg;
    logic [CHAIN_AW-1:0] out_idx_reg;
    logic [CHAIN_AW-1:0] chain_rd_idx_reg;

    logic                in_fire;
    logic                out_free;
    logic                msg_re;
    logic [MSG_AW-1:0]   msg_raddr;
    word_t               msg_rdata;
    logic                chain_re;
    logic                chain_we;
    logic [CHAIN_AW-1:0] chain_raddr;
    word_t               chain_rdata;
    word_t               chain_val;
    word_t               fin_sum;
    logic [3:0]          seq_m1;
    step_ctl_t           step_ctl;
    word_t               step_t_out;

    assign in_ready = (state_reg == ST_LOAD);
    assign in_fire  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign seq_m1   = seq_cnt_reg - 4'd1;

    always_comb
    begin
        msg_re    = 1'b0;
        msg_raddr = '0;
        if (state_reg == ST_INIT && seq_cnt_reg == INIT_DONE)
        begin
            msg_re = 1'b1;
        end
        else if (state_reg == ST_ROUND)
        begin
            msg_re = 1'b1;
            if (step_cnt_reg == 2'(STEP_LAST))
            begin
                msg_raddr = {~round_cnt_reg[0], 3'b000};
            end
            else
            begin
                msg_raddr = {round_cnt_reg[0], 1'b0, step_cnt_reg + 2'd1};
            end
        end
    end

    assign chain_raddr = seq_cnt_reg[CHAIN_AW-1:0];
    assign chain_re    = (state_reg == ST_FIN_RD)
                         || (state_reg == ST_INIT && seq_cnt_reg < INIT_DONE);
    assign chain_we    = (state_reg == ST_FIN_ADD) && out_free;

    always_comb
    begin
        if (fresh_reg)
        begin
            chain_val = (chain_rd_idx_reg == '0) ? fresh_val_reg : '0;
        end
        else
        begin
            chain_val = chain_rdata;
        end
    end

    assign fin_sum = chain_val + work_reg[seq_cnt_reg[CHAIN_AW-1:0]];

    assign step_ctl.step        = step_t'(step_cnt_reg);
    assign step_ctl.round_const = ROUND_CONST[round_cnt_reg];

    bhc_ram #(
        .Width (WORD_W),
        .Depth (MSG_DEPTH)
    ) u_msg_ram (
        .clk   (clk),
        .we    (in_fire),
        .waddr (word_cnt_reg),
        .wdata (message_word),
        .re    (msg_re),
        .raddr (msg_raddr),
        .rdata (msg_rdata)
    );

    bhc_ram #(
        .Width (WORD_W),
        .Depth (CHAIN_DEPTH)
    ) u_chain_ram (
        .clk   (clk),
        .we    (chain_we),
        .waddr (seq_cnt_reg[CHAIN_AW-1:0]),
        .wdata (fin_sum),
        .re    (chain_re),
        .raddr (chain_raddr),
        .rdata (chain_rdata)
    );

    bhc_step u_step (
        .work   (work_reg),
        .t_prev (t_reg),
        .msg    (msg_rdata),
        .ctl    (step_ctl),
        .t_out  (step_t_out)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            word_cnt_reg  <= '0;
            seq_cnt_reg   <= '0;
            round_cnt_reg <= '0;
            step_cnt_reg  <= '0;
            fresh_reg     <= 1'b1;
            fresh_val_reg <= IV_RESET;
            iv_reg        <= IV_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                iv_reg <= cfg_wdata;
            end
            if (chain_we)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (chain_re)
            begin
                chain_rd_idx_reg <= chain_raddr;
            end

            case (state_reg)
                ST_LOAD:
                begin
                    if (in_fire)
                    begin
                        word_cnt_reg <= word_cnt_reg + MSG_AW'(1);
                        if (word_cnt_reg == '0 && restart_chain)
                        begin
                            fresh_reg     <= 1'b1;
                            fresh_val_reg <= iv_reg;
                        end
                        if (word_cnt_reg == LAST_WORD_CNT)
                        begin
                            state_reg   <= ST_INIT;
                            seq_cnt_reg <= '0;
                        end
                    end
                end
                ST_INIT:
                begin
                    if (seq_cnt_reg != '0)
                    begin
                        work_reg[seq_m1[CHAIN_AW-1:0]] <= chain_val;
                    end
                    if (seq_cnt_reg == INIT_DONE)
                    begin
                        state_reg     <= ST_ROUND;
                        round_cnt_reg <= '0;
                        step_cnt_reg  <= '0;
                    end
                    else
                    begin
                        seq_cnt_reg <= seq_cnt_reg + 4'd1;
                    end
                end
                ST_ROUND:
                begin
                    t_reg <= step_t_out;
                    if (step_cnt_reg == 2'(STEP_FIRST))
                    begin
                        t1_reg <= step_t_out;
                    end
                    if (step_cnt_reg == 2'(STEP_LAST))
                    begin
                        work_reg[0] <= step_t_out;
                        work_reg[1] <= work_reg[2];
                        work_reg[2] <= work_reg[3];
                        work_reg[3] <= work_reg[4];
                        work_reg[4] <= work_reg[5];
                        work_reg[5] <= work_reg[6];
                        work_reg[6] <= work_reg[7];
                        work_reg[7] <= t1_reg;
                        step_cnt_reg <= '0;
                        if (round_cnt_reg == LAST_ROUND)
                        begin
                            state_reg   <= ST_FIN_RD;
                            seq_cnt_reg <= '0;
                        end
                        else
                        begin
                            round_cnt_reg <= round_cnt_reg + ROUND_W'(1);
                        end
                    end
                    else
                    begin
                        step_cnt_reg <= step_cnt_reg + 2'd1;
                    end
                end
                ST_FIN_RD:
                begin
                    state_reg <= ST_FIN_ADD;
                end
                ST_FIN_ADD:
                begin
                    if (out_free)
                    begin
                        out_word_reg  <= fin_sum;
                        out_idx_reg   <= seq_cnt_reg[CHAIN_AW-1:0];
                        if (seq_cnt_reg[CHAIN_AW-1:0] == LAST_CHAIN)
                        begin
                            state_reg   <= ST_LOAD;
                            fresh_reg   <= 1'b0;
                            seq_cnt_reg <= '0;
                        end
                        else
                        begin
                            state_reg   <= ST_FIN_RD;
                            seq_cnt_reg <= seq_cnt_reg + 4'd1;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_LOAD;
                end
            endcase
        end
    end

    assign out_valid  = out_valid_reg;
    assign hash_word  = out_word_reg;
    assign word_index = out_idx_reg;
    assign last_word  = (out_idx_reg == LAST_CHAIN);

    `BHC_ASSERT(a_word_cnt_idle, (state_reg != ST_LOAD) |-> (word_cnt_reg == '0))
    `BHC_ASSERT(a_block_start, (in_fire && word_cnt_reg == LAST_WORD_CNT) |=> (state_reg == ST_INIT))
    `BHC_ASSERT(a_result_written, $rose(out_valid_reg) |-> $past(chain_we))
    `BHC_ASSERT_NEVER(a_no_overlap, in_fire && chain_we)

endmodule
